>>> rtl/fragment_modulate_blend_assert.svh
// ----------------------------------------------------------------------------
// fragment_modulate_blend_assert.svh
// Assertion macros used by the fragment blend top level.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_MODULATE_BLEND_ASSERT_SVH
`define FRAGMENT_MODULATE_BLEND_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FMB_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("fmb: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FMB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fmb: next-cycle check failed");

`endif

>>> rtl/fmb_pkg.sv
// ----------------------------------------------------------------------------
// fmb_pkg
// Types, codes and arithmetic helpers of the fragment blend pipeline.
// ----------------------------------------------------------------------------
package fmb_pkg;

  localparam int unsigned NumStages = 5;

  localparam logic [7:0]  ChMax      = 8'd255;
  localparam logic [15:0] Recip255   = 16'd32897;  // 2^23 / 255, rounded up

  typedef enum logic [1:0] {
    OP_OVER = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2
  } blend_op_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } conv_en_t;

  typedef struct packed {
    logic s4;
    logic s5;
  } blend_en_t;

  // floor(x / 255), exact for x below 66052
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [32:0] p;
    p = {16'b0, x} * {17'b0, Recip255};
    return p[31:23];
  endfunction

endpackage

>>> rtl/fmb_chan_conv.sv
// ----------------------------------------------------------------------------
// fmb_chan_conv
// One color channel: texel modulate, round and clamp to a byte. Three stages.
// ----------------------------------------------------------------------------
module fmb_chan_conv (
  input  logic                clk_i,
  input  fmb_pkg::conv_en_t   en_i,
  input  logic                textured_i,
  input  logic signed [16:0]  color_i,
  input  logic        [7:0]   texel_i,
  output logic        [7:0]   byte_o
);
  import fmb_pkg::*;

  logic signed [25:0] prod;
  logic signed [26:0] num_d, num_q;
  logic               tex1_q, tex2_q;
  logic        [16:0] x_d, x_q;
  logic        [8:0]  q;
  logic        [7:0]  byte_d, byte_q;

  // stage 1: 2*t*c + 65280, or c + 128
  always_comb begin
    prod = $signed({17'b0, texel_i}) * $signed({{9{color_i[16]}}, color_i});
    if (textured_i) begin
      num_d = $signed({prod, 1'b0}) + 27'sd65280;
    end else begin
      num_d = $signed({{10{color_i[16]}}, color_i}) + 27'sd128;
    end
  end

  // stage 2: negative to zero, drop the low fraction
  always_comb begin
    if (num_q[26]) begin
      x_d = '0;
    end else if (tex1_q) begin
      x_d = {1'b0, num_q[24:9]};
    end else begin
      x_d = {8'b0, num_q[16:8]};
    end
  end

  // stage 3: divide by 255 when textured, clamp
  always_comb begin
    q      = tex2_q ? div255(x_q) : x_q[8:0];
    byte_d = q[8] ? ChMax : q[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      num_q  <= num_d;
      tex1_q <= textured_i;
    end
    if (en_i.s2) begin
      x_q    <= x_d;
      tex2_q <= tex1_q;
    end
    if (en_i.s3) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/fmb_blend.sv
// ----------------------------------------------------------------------------
// fmb_blend
// Source/destination combine: products in stage 4, divide and select in 5.
// ----------------------------------------------------------------------------
module fmb_blend (
  input  logic                clk_i,
  input  fmb_pkg::blend_en_t  en_i,
  input  logic                bgra_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          src_red_i,
  input  logic [7:0]          src_green_i,
  input  logic [7:0]          src_blue_i,
  input  logic [7:0]          src_alpha_i,
  input  logic [31:0]         dest_i,
  output logic [31:0]         pixel_o
);
  import fmb_pkg::*;

  logic [7:0]  s   [3];
  logic [7:0]  inv;
  logic        pass_d, pass_q;
  logic [15:0] pa_d [3];
  logic [15:0] pb_d [3];
  logic [15:0] pa_q [3];
  logic [15:0] pb_q [3];
  logic [15:0] pd_d, pd_q;
  logic [31:0] dest_q;
  logic [1:0]  op_q;
  logic [7:0]  sa_q;
  logic [31:0] pix_d, pix_q;

  // stage 4
  always_comb begin
    if (bgra_i) begin
      s[0] = src_blue_i;
      s[2] = src_red_i;
    end else begin
      s[0] = src_red_i;
      s[2] = src_blue_i;
    end
    s[1] = src_green_i;
    inv  = ChMax - src_alpha_i;
    case (op_i)
      OP_OVER, OP_ADD, OP_MUL: pass_d = (src_alpha_i == 8'd0);
      default:                 pass_d = 1'b1;
    endcase
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = {8'b0, s[i]} * {8'b0, src_alpha_i};
      if (op_i == OP_MUL) begin
        pb_d[i] = {8'b0, dest_i[8*i +: 8]} * {8'b0, s[i]};
      end else begin
        pb_d[i] = {8'b0, dest_i[8*i +: 8]} * {8'b0, inv};
      end
    end
    pd_d = {8'b0, dest_i[31:24]} * {8'b0, inv};
  end

  // stage 5
  always_comb begin
    logic [8:0] qa, qb, qs, sum;
    qa    = '0;
    qb    = '0;
    qs    = '0;
    sum   = '0;
    pix_d = dest_q;
    if (!pass_q) begin
      for (int i = 0; i < 3; i++) begin
        qa  = div255({1'b0, pa_q[i]});
        qb  = div255({1'b0, pb_q[i]});
        qs  = div255({1'b0, pa_q[i]} + {1'b0, pb_q[i]});
        sum = {1'b0, dest_q[8*i +: 8]} + qa;
        case (op_q)
          OP_ADD:  pix_d[8*i +: 8] = sum[8] ? ChMax : sum[7:0];
          OP_MUL:  pix_d[8*i +: 8] = qb[7:0];
          default: pix_d[8*i +: 8] = qs[7:0];
        endcase
      end
      qa = div255({1'b0, pd_q});
      if (op_q == OP_OVER) begin
        pix_d[31:24] = sa_q + qa[7:0];
      end else begin
        pix_d[31:24] = ChMax;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pd_q   <= pd_d;
      pass_q <= pass_d;
      dest_q <= dest_i;
      op_q   <= op_i;
      sa_q   <= src_alpha_i;
    end
    if (en_i.s5) begin
      pix_q <= pix_d;
    end
  end

  assign pixel_o = pix_q;

endmodule

>>> rtl/fragment_modulate_blend.sv
// Five-stage pipeline, one pixel per clock sustained while the output is
// taken. Stages 1-3 modulate each color channel by the texel and round it
// to a byte (one multiplier per channel, then a reciprocal multiply for the
// divide by 255); stages 4-5 form the blend products and divide them by 255.
// Each stage holds its own valid bit, so empty stages fill while the output
// beat waits, and a full pipe stalls input only when the output is not taken.
// The channel order register is written through its own port, which is
// always ready.
// ----------------------------------------------------------------------------
// fragment_modulate_blend
// Per-pixel texture modulate and RGBA8 blend stage.
// ----------------------------------------------------------------------------
module fragment_modulate_blend (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_bgra_order_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic               textured_i,
  input  logic signed [16:0] color_red_i,
  input  logic signed [16:0] color_green_i,
  input  logic signed [16:0] color_blue_i,
  input  logic signed [16:0] color_alpha_i,
  input  logic [7:0]         texel_red_i,
  input  logic [7:0]         texel_green_i,
  input  logic [7:0]         texel_blue_i,
  input  logic [7:0]         texel_alpha_i,
  input  logic [31:0]        dest_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        new_pixel_o
);
  import fmb_pkg::*;

  `include "fragment_modulate_blend_assert.svh"

  logic                 bgra_q;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] ld;
  conv_en_t             conv_en;
  blend_en_t            blend_en;
  logic [1:0]           op_q  [3];
  logic [31:0]          dest_q[3];
  logic [7:0]           src_r, src_g, src_b, src_a;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bgra_q <= 1'b0;
    end else if (cfg_valid_i) begin
      bgra_q <= cfg_bgra_order_i;
    end
  end

  // per-stage ready: a stage can load when empty or when its successor moves
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      ld[k] = rdy[k] && vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // op and destination ride alongside the channel converters
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      op_q[0]   <= op_i;
      dest_q[0] <= dest_pixel_i;
    end
    for (int k = 1; k < 3; k++) begin
      if (ld[k]) begin
        op_q[k]   <= op_q[k-1];
        dest_q[k] <= dest_q[k-1];
      end
    end
  end

  assign conv_en  = '{s1: ld[0], s2: ld[1], s3: ld[2]};
  assign blend_en = '{s4: ld[3], s5: ld[4]};

  fmb_chan_conv u_conv_r (
    .clk_i, .en_i(conv_en), .textured_i,
    .color_i(color_red_i), .texel_i(texel_red_i), .byte_o(src_r)
  );

  fmb_chan_conv u_conv_g (
    .clk_i, .en_i(conv_en), .textured_i,
    .color_i(color_green_i), .texel_i(texel_green_i), .byte_o(src_g)
  );

  fmb_chan_conv u_conv_b (
    .clk_i, .en_i(conv_en), .textured_i,
    .color_i(color_blue_i), .texel_i(texel_blue_i), .byte_o(src_b)
  );

  fmb_chan_conv u_conv_a (
    .clk_i, .en_i(conv_en), .textured_i,
    .color_i(color_alpha_i), .texel_i(texel_alpha_i), .byte_o(src_a)
  );

  fmb_blend u_blend (
    .clk_i,
    .en_i        (blend_en),
    .bgra_i      (bgra_q),
    .op_i        (op_q[2]),
    .src_red_i   (src_r),
    .src_green_i (src_g),
    .src_blue_i  (src_b),
    .src_alpha_i (src_a),
    .dest_i      (dest_q[2]),
    .pixel_o     (new_pixel_o)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  `FMB_ASSERT_NEXT(a_in_lands, in_valid_i && in_ready_o, vld_q[0])
  `FMB_ASSERT_IMPLIES(a_full_stall, (&vld_q) && !out_ready_i, !in_ready_o)
  `FMB_ASSERT_IMPLIES(a_bubble_ready, !(&vld_q), in_ready_o)
  `FMB_ASSERT_NEXT(a_cfg_write, cfg_valid_i && cfg_ready_o, bgra_q == $past(cfg_bgra_order_i))

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fragment_modulate_blend: texel modulate, byte rounding and the three
// blend modes in both channel orders. A short table of hand-made fragments
// runs first, then bursts of random fragments under varying output stalls.
// Every output pixel is compared against its table entry or a local model.
// ----------------------------------------------------------------------------
module testbench;
  import fmb_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic signed [16:0] QFull = 17'sd65280;
  localparam logic signed [16:0] QMax  = 17'sd65535;
  localparam logic signed [16:0] QMin  = 17'h10000;
  localparam logic signed [16:0] QHalf = 17'sd32768;
  localparam int RandPerPhase = 250;

  typedef struct {
    logic [1:0]         op;
    logic               textured;
    logic signed [16:0] cr, cg, cb, ca;
    logic [7:0]         tr, tg, tb, ta;
    logic [31:0]        dest;
  } frag_t;

  typedef struct {
    frag_t       f;
    logic        bgra;
    logic        typed;
    logic [31:0] pixel;
  } frag_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_bgra_order_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = '0;
  logic               textured_i = 1'b0;
  logic signed [16:0] color_red_i = '0;
  logic signed [16:0] color_green_i = '0;
  logic signed [16:0] color_blue_i = '0;
  logic signed [16:0] color_alpha_i = '0;
  logic [7:0]         texel_red_i = '0;
  logic [7:0]         texel_green_i = '0;
  logic [7:0]         texel_blue_i = '0;
  logic [7:0]         texel_alpha_i = '0;
  logic [31:0]        dest_pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        new_pixel_o;

  logic [31:0] pixel_q[$];
  frag_row_t   frag_table[$];
  logic        order_model = 1'b0;
  logic [31:0] want;
  int          pixel_errors = 0;
  int          frags_sent = 0;
  int          pixels_seen = 0;
  int          order_writes = 0;
  int          burst_left = 0;
  int          rx_cycle = 0;

  fragment_modulate_blend uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_bgra_order_i (cfg_bgra_order_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .textured_i       (textured_i),
    .color_red_i      (color_red_i),
    .color_green_i    (color_green_i),
    .color_blue_i     (color_blue_i),
    .color_alpha_i    (color_alpha_i),
    .texel_red_i      (texel_red_i),
    .texel_green_i    (texel_green_i),
    .texel_blue_i     (texel_blue_i),
    .texel_alpha_i    (texel_alpha_i),
    .dest_pixel_i     (dest_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .new_pixel_o      (new_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("%0t: timeout, %0d pixels outstanding", $time, pixel_q.size());
    $display("[fragment_modulate_blend] ERROR");
    $finish;
  end

  function automatic logic [7:0] channel_byte(input logic signed [16:0] c,
                                              input logic [7:0] t,
                                              input logic tex);
    longint num;
    longint q;
    if (tex) begin
      num = 2 * longint'(t) * longint'(c) + 65280;
      q = num / 130560;
    end else begin
      num = longint'(c) + 128;
      q = num / 256;
    end
    if (num < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic logic [31:0] blend_pixel(input frag_t f, input logic bgra);
    int sr, sg, sb, sa, inv, n, i;
    int d[4];
    int s[3];
    logic [31:0] res;
    sr = int'(channel_byte(f.cr, f.tr, f.textured));
    sg = int'(channel_byte(f.cg, f.tg, f.textured));
    sb = int'(channel_byte(f.cb, f.tb, f.textured));
    sa = int'(channel_byte(f.ca, f.ta, f.textured));
    for (i = 0; i < 4; i++) d[i] = int'(f.dest[8*i +: 8]);
    if (bgra) begin
      s[0] = sb; s[1] = sg; s[2] = sr;
    end else begin
      s[0] = sr; s[1] = sg; s[2] = sb;
    end
    if (sa != 0 && f.op != OpUnused) begin
      inv = 255 - sa;
      for (i = 0; i < 3; i++) begin
        if (f.op == OP_ADD) begin
          n = d[i] + s[i] * sa / 255;
          d[i] = (n > 255) ? 255 : n;
        end else if (f.op == OP_MUL) begin
          d[i] = d[i] * s[i] / 255;
        end else begin
          d[i] = (s[i] * sa + d[i] * inv) / 255;
        end
      end
      if (f.op == OP_OVER) d[3] = sa + d[3] * inv / 255;
      else d[3] = 255;
    end
    for (i = 0; i < 4; i++) res[8*i +: 8] = d[i][7:0];
    return res;
  endfunction

  function automatic logic signed [16:0] rand_q98(input bit is_alpha);
    int pick;
    logic signed [16:0] v;
    pick = $urandom_range(0, 9);
    v = 17'($urandom_range(0, 65280));
    if (pick == 0) v = 17'($urandom_range(0, 131071));
    else if (pick == 1) v = 17'sd0;
    else if (pick == 2) v = QFull;
    else if (is_alpha && pick == 3) v = 17'sd0;
    else if (is_alpha && pick == 4) v = QFull;
    return v;
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    f.op = ($urandom_range(0, 15) == 0) ? OpUnused : 2'($urandom_range(0, 2));
    f.textured = 1'($urandom_range(0, 1));
    f.cr = rand_q98(1'b0);
    f.cg = rand_q98(1'b0);
    f.cb = rand_q98(1'b0);
    f.ca = rand_q98(1'b1);
    f.tr = 8'($urandom_range(0, 255));
    f.tg = 8'($urandom_range(0, 255));
    f.tb = 8'($urandom_range(0, 255));
    f.ta = 8'($urandom_range(0, 255));
    f.dest = $urandom();
    return f;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic tex,
                         input logic signed [16:0] cr, cg, cb, ca,
                         input logic [7:0] tr, tg, tb, ta,
                         input logic [31:0] dest, input logic bgra,
                         input logic typed, input logic [31:0] pixel);
    frag_row_t r;
    r.f.op = op; r.f.textured = tex;
    r.f.cr = cr; r.f.cg = cg; r.f.cb = cb; r.f.ca = ca;
    r.f.tr = tr; r.f.tg = tg; r.f.tb = tb; r.f.ta = ta;
    r.f.dest = dest;
    r.bgra = bgra; r.typed = typed; r.pixel = pixel;
    frag_table.push_back(r);
  endtask

  // Called right after a rising edge; returns at the edge that took the beat.
  task automatic send_frag(input frag_t f, input logic typed, input logic [31:0] pixel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    op_i          <= f.op;
    textured_i    <= f.textured;
    color_red_i   <= f.cr;
    color_green_i <= f.cg;
    color_blue_i  <= f.cb;
    color_alpha_i <= f.ca;
    texel_red_i   <= f.tr;
    texel_green_i <= f.tg;
    texel_blue_i  <= f.tb;
    texel_alpha_i <= f.ta;
    dest_pixel_i  <= f.dest;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_q.push_back(typed ? pixel : blend_pixel(f, order_model));
    frags_sent++;
    burst_left--;
  endtask

  // Drain the pipe, then write the channel order.
  task automatic write_order(input logic bgra);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_bgra_order_i <= bgra;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_model = bgra;
    order_writes++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        pixel_errors++;
        $display("%0t: new_pixel expected none, actual %08h", $time, new_pixel_o);
      end else begin
        want = pixel_q.pop_front();
        if (new_pixel_o !== want) begin
          pixel_errors++;
          $display("%0t: new_pixel expected %08h, actual %08h", $time, want, new_pixel_o);
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 2) != 0);
      default: out_ready_i <= ((rx_cycle % 7) < 4);
    endcase
  end

  initial begin
    int i, k, guard;
    logic phase_order;
    // typed rows: zero alpha, unused op, full/extreme colors, rounding edges
    add_row(OP_OVER, 0, QFull, QFull, QFull, 17'sd0, 0, 0, 0, 0,
            32'h12345678, 0, 1, 32'h12345678);
    add_row(OpUnused, 0, QFull, QFull, QFull, QFull, 0, 0, 0, 0,
            32'hA5A5A5A5, 0, 1, 32'hA5A5A5A5);
    add_row(OP_OVER, 0, QFull, QFull, QFull, QFull, 0, 0, 0, 0,
            32'h00000000, 0, 1, 32'hFFFFFFFF);
    add_row(OP_OVER, 0, QMax, QMin, QHalf, QMax, 0, 0, 0, 0,
            32'h5A5A5A5A, 0, 1, 32'hFF8000FF);
    add_row(OP_ADD, 0, QFull, QFull, QFull, QFull, 0, 0, 0, 0,
            32'h01020304, 0, 1, 32'hFFFFFFFF);
    add_row(OP_ADD, 0, 17'sd0, 17'sd0, 17'sd0, QFull, 0, 0, 0, 0,
            32'h10203040, 0, 1, 32'hFF203040);
    add_row(OP_MUL, 0, QFull, QFull, QFull, QFull, 0, 0, 0, 0,
            32'h80402010, 0, 1, 32'hFF402010);
    add_row(OP_MUL, 0, 17'sd0, 17'sd0, 17'sd0, QFull, 0, 0, 0, 0,
            32'hFFFFFFFF, 0, 1, 32'hFF000000);
    add_row(OP_OVER, 1, QFull, QFull, QFull, QFull, 0, 0, 0, 0,
            32'hDEADBEEF, 0, 1, 32'hDEADBEEF);
    add_row(OP_OVER, 1, QFull, QFull, QFull, QFull, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            32'h00000000, 0, 1, 32'hFFFFFFFF);
    add_row(OP_ADD, 1, QFull, QFull, QFull, QMin, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            32'h0BADF00D, 0, 1, 32'h0BADF00D);
    add_row(OP_MUL, 1, QMax, QMax, QMax, QMax, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            32'h80808080, 0, 1, 32'hFF808080);
    add_row(OP_ADD, 0, QFull, QFull, QFull, 17'sd127, 0, 0, 0, 0,
            32'h33333333, 0, 1, 32'h33333333);
    // model-checked rows
    add_row(OP_OVER, 0, 17'sd25600, 17'sd12800, 17'sd51200, QHalf, 0, 0, 0, 0,
            32'h80C04020, 0, 0, '0);
    add_row(OP_ADD, 0, 17'sd25600, 17'sd12800, 17'sd51200, 17'sd16384, 0, 0, 0, 0,
            32'h40F0F0F0, 0, 0, '0);
    add_row(OP_MUL, 1, QFull, QHalf, 17'sd128, QFull, 8'h80, 8'hC0, 8'hFF, 8'h40,
            32'h7F7F7F7F, 0, 0, '0);
    add_row(OP_OVER, 1, 17'sd1000, QMax, QMin, 17'sd40000, 8'h11, 8'h22, 8'h33, 8'h99,
            32'h01234567, 0, 0, '0);
    add_row(OP_OVER, 0, 17'sd127, 17'sd128, 17'sd383, 17'sd128, 0, 0, 0, 0,
            32'hFFFFFFFF, 0, 0, '0);
    // blue-first order
    add_row(OP_OVER, 0, QMax, QMin, 17'sd0, QMax, 0, 0, 0, 0,
            32'h00000000, 1, 1, 32'hFFFF0000);
    add_row(OP_OVER, 0, QFull, QFull, QFull, 17'sd0, 0, 0, 0, 0,
            32'h89ABCDEF, 1, 1, 32'h89ABCDEF);
    add_row(OP_ADD, 0, QFull, 17'sd0, QHalf, QFull, 0, 0, 0, 0,
            32'h00000000, 1, 0, '0);
    add_row(OP_MUL, 1, QFull, QHalf, 17'sd0, QFull, 8'hFF, 8'hFF, 8'hFF, 8'h80,
            32'hC0C0C0C0, 1, 0, '0);
    add_row(OP_OVER, 1, 17'sd30000, 17'sd60000, 17'sd9000, 17'sd50000,
            8'hF0, 8'h0F, 8'hAA, 8'h55, 32'h3C5A96E1, 1, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset order (red first) is used untouched by the first rows
    for (i = 0; i < frag_table.size(); i++) begin
      if (frag_table[i].bgra != order_model) write_order(frag_table[i].bgra);
      send_frag(frag_table[i].f, frag_table[i].typed, frag_table[i].pixel);
    end

    for (k = 0; k < 4; k++) begin
      phase_order = (k % 2 == 0);
      write_order(phase_order);
      for (i = 0; i < RandPerPhase; i++) send_frag(rand_frag(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pixel_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (pixel_q.size() != 0) begin
      pixel_errors += pixel_q.size();
      $display("%0t: %0d expected pixels never arrived", $time, pixel_q.size());
    end

    $display("covered %0d fragments (%0d from the table), %0d pixels compared,",
             frags_sent, frag_table.size(), pixels_seen);
    $display("%0d channel order writes, %0d mismatches", order_writes, pixel_errors);
    if (pixel_errors == 0) begin
      $display("[fragment_modulate_blend] OK");
    end else begin
      $display("[fragment_modulate_blend] ERROR");
    end
    $finish;
  end

endmodule
